// File: rtl/console_mod_hotkey_controller_top_macros.svh
// ----------------------------------------------------------------------------
// Hotkey controller assertion macros
// Concurrent checks clocked by i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CONSOLE_MOD_HOTKEY_CONTROLLER_TOP_MACROS_SVH
`define CONSOLE_MOD_HOTKEY_CONTROLLER_TOP_MACROS_SVH

// consequent checked in the same cycle
`define HKC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define HKC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/hkc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkc_pkg
// Shared types and constants of the hotkey controller.
// ----------------------------------------------------------------------------
package hkc_pkg;

    localparam int TICK_W = 13;

    typedef enum logic [2:0] {
        KIND_TICK       = 3'd0,
        KIND_SEL_FALL   = 3'd1,
        KIND_SEL_RISE   = 3'd2,
        KIND_RST_FALL   = 3'd3,
        KIND_MRST_FALL  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        REG_STORED_REGION = 2'd0,
        REG_HOLD_TICKS    = 2'd1,
        REG_LONG_HOLD     = 2'd2,
        REG_PRESS_WINDOW  = 2'd3
    } t_reg_idx;

    localparam logic [1:0] REGION_JAPAN    = 2'd0;
    localparam logic [1:0] REGION_AMERICAS = 2'd1;
    localparam logic [1:0] REGION_EUROPE   = 2'd2;
    localparam logic [1:0] REGION_INVALID  = 2'd3;

    localparam logic [2:0] DIV_FAST = 3'd5;
    localparam logic [2:0] DIV_STD  = 3'd7;

    localparam logic [1:0]        RST_STORED_REGION = REGION_INVALID;
    localparam logic [TICK_W-1:0] RST_HOLD_TICKS    = 13'd1000;
    localparam logic [TICK_W-1:0] RST_LONG_HOLD     = 13'd5000;
    localparam logic [TICK_W-1:0] RST_PRESS_WINDOW  = 13'd3000;

    typedef struct packed {
        t_kind kind;
        logic  line_ab;
        logic  line_sc;
        logic  line_up;
        logic  mega_mode;
    } t_item;

    typedef struct packed {
        logic [1:0]        stored_region;
        logic [TICK_W-1:0] hold_ticks;
        logic [TICK_W-1:0] long_hold_ticks;
        logic [TICK_W-1:0] press_window_ticks;
    } t_cfg;

    // stored region write, reloads the live region
    typedef struct packed {
        logic       valid;
        logic [1:0] region;
    } t_region_load;

    // field order matches the output beat, lowest field last
    typedef struct packed {
        logic [1:0] led_color;
        logic       tmss_skip;
        logic       save_region;
        logic       sms_reset;
        logic       sms_pause;
        logic       reset_pulse;
        logic [2:0] cpu_divider;
        logic       overclock;
        logic       region_export;
        logic       standard_ntsc;
        logic [1:0] region;
    } t_result;

    // invalid saved region falls back to americas
    function automatic logic [1:0] stored_to_region(input logic [1:0] stored);
        return (stored == REGION_INVALID) ? REGION_AMERICAS : stored;
    endfunction

endpackage

// File: rtl/console_mod_hotkey_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_mod_hotkey_controller_top
// Console hotkey controller: pad combos, reset presses and master-mode lines
// drive region, video standard, overclock and reset/save requests.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata: ab, sc, up, mega; tuser: kind
//  m_axis    out  m_axis_tvalid/tready      tdata: result fields
//  apb       in   psel/penable/pwrite/pready 4 registers at 0x0, 0x4, 0x8, 0xC
//
//  One beat in per cycle while the output register is empty or drained, one beat out per beat in.
//  State updates at the accepting edge; the result sits in the output register.
//  s_axis_tready is high while the output register is empty or being drained.
//  Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
`include "console_mod_hotkey_controller_top_macros.svh"

module console_mod_hotkey_controller_top import hkc_pkg::*; #(
    parameter int COUNT_BITS = 13
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] line_ab, [1] line_sc, [2] line_up,
                                        // [3] mega_mode, [7:4] zero
    input  logic [2:0]  s_axis_tuser,   // [2:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [1:0] region, [2] standard_ntsc,
                                        // [3] region_export, [4] overclock,
                                        // [7:5] cpu_divider, [8] reset_pulse,
                                        // [9] sms_pause, [10] sms_reset,
                                        // [11] save_region, [12] tmss_skip,
                                        // [14:13] led_color, [15] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg         cfg;
    t_region_load load;
    t_item        item;
    t_result      result;
    logic         accept;

    logic    r_m_valid;
    t_result r_result;

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign item.kind      = t_kind'(s_axis_tuser);
    assign item.line_ab   = s_axis_tdata[0];
    assign item.line_sc   = s_axis_tdata[1];
    assign item.line_up   = s_axis_tdata[2];
    assign item.mega_mode = s_axis_tdata[3];

    hkc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg),
        .o_load  (load)
    );

    hkc_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (item),
        .i_cfg    (cfg),
        .i_load   (load),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (accept) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= result;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {1'b0, r_result};

    `HKC_ASSERT_NEXT(a_accept_gives_beat, s_axis_tvalid && s_axis_tready, m_axis_tvalid, "accepted beat produced no result")
    `HKC_ASSERT_SAME(a_save_with_reset, m_axis_tvalid && r_result.save_region, r_result.reset_pulse, "region save without reset pulse")
    `HKC_ASSERT_SAME(a_region_led, m_axis_tvalid, r_result.region != REGION_INVALID && r_result.led_color == r_result.region + 2'd1, "region or led code inconsistent")
    `HKC_ASSERT_SAME(a_sms_exclusive, m_axis_tvalid, !(r_result.sms_pause && r_result.sms_reset), "pause and reset requested together")

endmodule

// File: rtl/hkc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkc_cfg
// APB register file: stored region and the three tick thresholds.
// ----------------------------------------------------------------------------
module hkc_cfg import hkc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    output t_cfg         o_cfg,
    output t_region_load o_load
);

    logic [1:0]        r_stored_region;
    logic [TICK_W-1:0] r_hold_ticks;
    logic [TICK_W-1:0] r_long_hold_ticks;
    logic [TICK_W-1:0] r_press_window_ticks;

    logic     wr_en;
    t_reg_idx reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored_region      <= RST_STORED_REGION;
            r_hold_ticks         <= RST_HOLD_TICKS;
            r_long_hold_ticks    <= RST_LONG_HOLD;
            r_press_window_ticks <= RST_PRESS_WINDOW;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_STORED_REGION: r_stored_region      <= pwdata[1:0];
                REG_HOLD_TICKS:    r_hold_ticks         <= pwdata[TICK_W-1:0];
                REG_LONG_HOLD:     r_long_hold_ticks    <= pwdata[TICK_W-1:0];
                REG_PRESS_WINDOW:  r_press_window_ticks <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_STORED_REGION: prdata = {30'd0, r_stored_region};
            REG_HOLD_TICKS:    prdata = {{(32-TICK_W){1'b0}}, r_hold_ticks};
            REG_LONG_HOLD:     prdata = {{(32-TICK_W){1'b0}}, r_long_hold_ticks};
            REG_PRESS_WINDOW:  prdata = {{(32-TICK_W){1'b0}}, r_press_window_ticks};
            default:           prdata = 32'd0;
        endcase
    end

    assign o_cfg.stored_region      = r_stored_region;
    assign o_cfg.hold_ticks         = r_hold_ticks;
    assign o_cfg.long_hold_ticks    = r_long_hold_ticks;
    assign o_cfg.press_window_ticks = r_press_window_ticks;

    assign o_load.valid  = wr_en && (reg_idx == REG_STORED_REGION);
    assign o_load.region = pwdata[1:0];

endmodule

// File: rtl/hkc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkc_core
// Pad latch, combo hold counter, press window and region/clock state.
// Updates all state in the cycle a beat is accepted and presents the result.
// ----------------------------------------------------------------------------
module hkc_core import hkc_pkg::*; #(
    parameter int COUNT_BITS = 13
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  t_item        i_item,
    input  t_cfg         i_cfg,
    input  t_region_load i_load,
    output t_result      o_result
);

    localparam int CMP_W = (COUNT_BITS > TICK_W) ? COUNT_BITS : TICK_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    typedef enum logic [2:0] {
        C_NONE   = 3'd0,
        C_IGR    = 3'd1,
        C_EURO   = 3'd2,
        C_OC     = 3'd3,
        C_SPAUSE = 3'd4,
        C_SRESET = 3'd5,
        C_CYCLE  = 3'd6
    } t_combo;

    logic [3:0]            r_pad,         n_pad;
    logic [COUNT_BITS-1:0] r_hold_count,  n_hold_count;
    t_combo                r_held,        n_held;
    logic [1:0]            r_region,      n_region;
    logic [1:0]            r_cycle_idx,   n_cycle_idx;
    logic                  r_euro,        n_euro;
    logic                  r_ntsc,        n_ntsc;
    logic                  r_oc,          n_oc;
    logic                  r_fast,        n_fast;
    logic [2:0]            r_press_count, n_press_count;
    logic [COUNT_BITS-1:0] r_press_timer, n_press_timer;

    t_combo            held_ok_combo;
    t_combo            pick_combo;
    logic [TICK_W-1:0] thr;
    logic              fire;
    logic              do_cycle;
    logic [1:0]        cycle_next;
    logic              req_rst, req_pause, req_sreset, req_save, req_tmss;

    function automatic logic combo_true(input t_combo c, input logic [3:0] pad,
                                        input logic ab, input logic sc,
                                        input logic up);
        logic res;
        case (c)
            C_IGR:    res = (pad == 4'hF);
            C_EURO:   res = (pad == 4'h7);
            C_OC:     res = (pad == 4'h5);
            C_SPAUSE: res = !ab && !sc && !up;
            C_SRESET: res = ab && !sc && !up;
            C_CYCLE:  res = (pad == 4'hE);
            default:  res = 1'b0;
        endcase
        return res;
    endfunction

    // fresh combo pick by priority; master combos only start in master mode
    always_comb begin
        if (r_pad == 4'hF)                                   pick_combo = C_IGR;
        else if (r_pad == 4'h7)                              pick_combo = C_EURO;
        else if (r_pad == 4'h5)                              pick_combo = C_OC;
        else if (!i_item.mega_mode && !i_item.line_ab && !i_item.line_sc
                 && !i_item.line_up)                         pick_combo = C_SPAUSE;
        else if (!i_item.mega_mode && i_item.line_ab && !i_item.line_sc
                 && !i_item.line_up)                         pick_combo = C_SRESET;
        else if (r_pad == 4'hE)                              pick_combo = C_CYCLE;
        else                                                 pick_combo = C_NONE;
    end

    assign held_ok_combo = (r_held != C_NONE &&
        combo_true(r_held, r_pad, i_item.line_ab, i_item.line_sc, i_item.line_up))
        ? r_held : pick_combo;

    assign cycle_next = (r_cycle_idx == 2'd2) ? 2'd0 : r_cycle_idx + 2'd1;

    always_comb begin
        n_pad         = r_pad;
        n_hold_count  = r_hold_count;
        n_held        = r_held;
        n_region      = r_region;
        n_cycle_idx   = r_cycle_idx;
        n_euro        = r_euro;
        n_ntsc        = r_ntsc;
        n_oc          = r_oc;
        n_fast        = r_fast;
        n_press_count = r_press_count;
        n_press_timer = r_press_timer;
        req_rst       = 1'b0;
        req_pause     = 1'b0;
        req_sreset    = 1'b0;
        req_save      = 1'b0;
        req_tmss      = 1'b0;
        do_cycle      = 1'b0;
        thr           = (held_ok_combo == C_SRESET) ? i_cfg.long_hold_ticks
                                                    : i_cfg.hold_ticks;
        fire          = 1'b0;

        case (i_item.kind)
            KIND_TICK: begin
                n_held = held_ok_combo;
                if (held_ok_combo == C_NONE) begin
                    n_hold_count = '0;
                end else if (held_ok_combo == r_held) begin
                    n_hold_count = (r_hold_count == CNT_MAX) ? r_hold_count
                                                             : r_hold_count + 1'b1;
                end else begin
                    n_hold_count = {{(COUNT_BITS-1){1'b0}}, 1'b1};
                end

                if (held_ok_combo != C_NONE) begin
                    fire = (CMP_W'(n_hold_count) == CMP_W'(thr));
                    if (fire) begin
                        case (held_ok_combo)
                            C_IGR: begin
                                if (r_euro) begin
                                    n_region = REGION_EUROPE;
                                    n_euro   = 1'b1;
                                    n_ntsc   = 1'b0;
                                    n_fast   = 1'b0;
                                end
                                req_rst = 1'b1;
                            end
                            C_EURO: begin
                                if (r_euro) begin
                                    n_ntsc = !r_ntsc;
                                    n_fast = 1'b0;
                                end
                            end
                            C_OC: begin
                                n_oc   = !r_oc;
                                n_fast = !r_oc;
                            end
                            C_SPAUSE: req_pause  = 1'b1;
                            C_SRESET: req_sreset = 1'b1;
                            C_CYCLE: begin
                                do_cycle = 1'b1;
                                req_save = 1'b1;
                                req_rst  = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end else begin
                    n_press_timer = (r_press_timer == CNT_MAX) ? r_press_timer
                                                               : r_press_timer + 1'b1;
                    if (i_item.mega_mode) begin
                        if (CMP_W'(n_press_timer) >= CMP_W'(i_cfg.press_window_ticks)) begin
                            n_press_count = 3'd0;
                        end else if (r_press_count >= 3'd3) begin
                            do_cycle = 1'b1;
                            req_save = 1'b1;
                            req_rst  = 1'b1;
                        end
                    end
                end

                if (do_cycle) begin
                    n_cycle_idx = cycle_next;
                    n_region    = cycle_next;
                    n_euro      = (cycle_next == REGION_EUROPE);
                    n_ntsc      = (cycle_next != REGION_EUROPE);
                    n_fast      = 1'b0;
                end
                if (req_rst) begin
                    n_press_count = 3'd0;
                end
            end
            KIND_SEL_FALL: begin
                n_pad[0] = !i_item.line_ab;
                n_pad[2] = !i_item.line_sc;
            end
            KIND_SEL_RISE: begin
                n_pad[1] = !i_item.line_ab;
                n_pad[3] = !i_item.line_sc;
            end
            KIND_RST_FALL: begin
                n_press_count = (r_press_count == 3'd7) ? r_press_count
                                                        : r_press_count + 3'd1;
                if (n_press_count == 3'd1) begin
                    n_press_timer = '0;
                end
            end
            KIND_MRST_FALL: begin
                if (i_item.line_up) begin
                    req_tmss      = 1'b1;
                    n_press_count = 3'd0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad         <= 4'd0;
            r_hold_count  <= '0;
            r_held        <= C_NONE;
            r_region      <= stored_to_region(RST_STORED_REGION);
            r_cycle_idx   <= 2'd0;
            r_euro        <= (stored_to_region(RST_STORED_REGION) == REGION_EUROPE);
            r_ntsc        <= (stored_to_region(RST_STORED_REGION) != REGION_EUROPE);
            r_oc          <= 1'b0;
            r_fast        <= 1'b0;
            r_press_count <= 3'd0;
            r_press_timer <= '0;
        end else if (i_accept) begin
            r_pad         <= n_pad;
            r_hold_count  <= n_hold_count;
            r_held        <= n_held;
            r_region      <= n_region;
            r_cycle_idx   <= n_cycle_idx;
            r_euro        <= n_euro;
            r_ntsc        <= n_ntsc;
            r_oc          <= n_oc;
            r_fast        <= n_fast;
            r_press_count <= n_press_count;
            r_press_timer <= n_press_timer;
        end else if (i_load.valid) begin
            r_region <= stored_to_region(i_load.region);
            r_euro   <= (stored_to_region(i_load.region) == REGION_EUROPE);
            r_ntsc   <= (stored_to_region(i_load.region) != REGION_EUROPE);
        end
    end

    assign o_result.region        = n_region;
    assign o_result.standard_ntsc = n_ntsc;
    assign o_result.region_export = (n_region != REGION_JAPAN);
    assign o_result.overclock     = n_oc;
    assign o_result.cpu_divider   = n_fast ? DIV_FAST : DIV_STD;
    assign o_result.reset_pulse   = req_rst;
    assign o_result.sms_pause     = req_pause;
    assign o_result.sms_reset     = req_sreset;
    assign o_result.save_region   = req_save;
    assign o_result.tmss_skip     = req_tmss;
    assign o_result.led_color     = n_region + 2'd1;

endmodule

// File: dv/console_mod_hotkey_controller_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_mod_hotkey_controller_top_tb
// Self-checking bench for the hotkey controller. A short directed table
// covers reset state, spare kinds, reset presses, master reset falls and every
// combo. Random combo holds, master-mode line holds, press bursts and noise
// follow across several register settings, the largest thresholds among them.
// Each output beat is compared field by field with a cycle-free behavioral
// predictor of the controller, or with the expected result of a typed directed row.
// ----------------------------------------------------------------------------
module console_mod_hotkey_controller_top_tb;
    import hkc_pkg::*;

    localparam int               CNT_W           = 13;
    localparam logic [CNT_W-1:0] CNT_TOP         = '1;
    localparam logic [2:0]       PRESS_TOP       = 3'd7;
    localparam logic [2:0]       PRESS_CYCLE_MIN = 3'd3;
    localparam int               WATCHDOG_CYCLES = 2000;
    localparam int               HOLD_OFF_CYCLES = 300;
    localparam int               SPAN_CAP        = 40;
    localparam int               DIR_ROWS        = 29;

    localparam logic [2:0] KIND_SPARE_5 = 3'd5;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    // pad button patterns, bit0 A, bit1 B, bit2 start, bit3 C
    localparam logic [3:0] PADS_NONE  = 4'h0;
    localparam logic [3:0] PADS_RESET = 4'hF;
    localparam logic [3:0] PADS_EURO  = 4'h7;
    localparam logic [3:0] PADS_TURBO = 4'h5;
    localparam logic [3:0] PADS_CYCLE = 4'hE;

    localparam logic [1:0] LED_GREEN = 2'd2;

    typedef enum logic [2:0] {
        CMB_NONE, CMB_RESET, CMB_EURO, CMB_TURBO, CMB_PAUSE, CMB_SMS_RESET, CMB_CYCLE
    } t_combo;

    typedef enum logic { ROW_BEAT, ROW_REG } t_row_op;

    typedef struct {
        t_row_op     op;
        logic [2:0]  kind;
        logic        ab;
        logic        sc;
        logic        up;
        logic        mega;
        t_reg_idx    reg_sel;
        logic [12:0] reg_val;
        bit          typed;
        t_result     want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [0] line_ab, [1] line_sc, [2] line_up, [3] mega_mode
    logic [2:0]  s_axis_tuser;   // [2:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [1:0] region, [2] standard_ntsc, [3] region_export,
                                 // [4] overclock, [7:5] cpu_divider, [8] reset_pulse,
                                 // [9] sms_pause, [10] sms_reset, [11] save_region,
                                 // [12] tmss_skip, [14:13] led_color
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    console_mod_hotkey_controller_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // predictor state and register copies
    logic [1:0]       cfg_stored;
    logic [CNT_W-1:0] cfg_hold;
    logic [CNT_W-1:0] cfg_long;
    logic [CNT_W-1:0] cfg_window;
    logic [3:0]       pad_state;
    logic [CNT_W-1:0] hold_cnt;
    t_combo           active_combo;
    logic [1:0]       region_q;
    logic [1:0]       cycle_sel;
    logic             euro_ok;
    logic             ntsc_q;
    logic             oc_q;
    logic             fast_q;
    logic [2:0]       presses;
    logic [CNT_W-1:0] press_age;

    t_result     pending_outputs[$];
    int unsigned mismatch_cnt;
    int unsigned beats_sent;
    int unsigned idle_cycles;
    bit          gaps_on;
    bit          rx_block_req;
    t_dir_row    dir_rows[DIR_ROWS];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    function automatic void reload_region();
        region_q = (cfg_stored == REGION_INVALID) ? REGION_AMERICAS : cfg_stored;
        euro_ok  = (region_q == REGION_EUROPE);
        ntsc_q   = (region_q != REGION_EUROPE);
    endfunction

    function automatic void apply_region(logic [1:0] r);
        region_q = r;
        euro_ok  = (r == REGION_EUROPE);
        ntsc_q   = (r != REGION_EUROPE);
        fast_q   = 1'b0;
    endfunction

    function automatic void next_region();
        cycle_sel = (cycle_sel == REGION_EUROPE) ? REGION_JAPAN : cycle_sel + 2'd1;
        apply_region(cycle_sel);
    endfunction

    function automatic void model_reset();
        cfg_stored   = RST_STORED_REGION;
        cfg_hold     = RST_HOLD_TICKS;
        cfg_long     = RST_LONG_HOLD;
        cfg_window   = RST_PRESS_WINDOW;
        pad_state    = PADS_NONE;
        hold_cnt     = '0;
        active_combo = CMB_NONE;
        cycle_sel    = REGION_JAPAN;
        oc_q         = 1'b0;
        fast_q       = 1'b0;
        presses      = '0;
        press_age    = '0;
        reload_region();
    endfunction

    function automatic void model_config(t_reg_idx idx, logic [12:0] val);
        case (idx)
            REG_STORED_REGION: begin
                cfg_stored = val[1:0];
                reload_region();
            end
            REG_HOLD_TICKS:   cfg_hold   = val;
            REG_LONG_HOLD:    cfg_long   = val;
            REG_PRESS_WINDOW: cfg_window = val;
            default: ;
        endcase
    endfunction

    function automatic bit combo_holds(t_combo c, logic ab, logic sc, logic up);
        case (c)
            CMB_RESET:     return pad_state == PADS_RESET;
            CMB_EURO:      return pad_state == PADS_EURO;
            CMB_TURBO:     return pad_state == PADS_TURBO;
            CMB_PAUSE:     return !ab && !sc && !up;
            CMB_SMS_RESET: return ab && !sc && !up;
            CMB_CYCLE:     return pad_state == PADS_CYCLE;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic t_result hotkey_predict(logic [2:0] kind, logic ab, logic sc,
                                               logic up, logic mega);
        t_combo           pick;
        logic [CNT_W-1:0] thr;
        logic             rs, pz, sr, sv, tm;
        t_result          r;
        rs = 1'b0; pz = 1'b0; sr = 1'b0; sv = 1'b0; tm = 1'b0;
        case (kind)
            KIND_TICK: begin
                // a held combo keeps its claim, else first match in priority order
                if (active_combo != CMB_NONE && combo_holds(active_combo, ab, sc, up))
                    pick = active_combo;
                else if (combo_holds(CMB_RESET, ab, sc, up))           pick = CMB_RESET;
                else if (combo_holds(CMB_EURO, ab, sc, up))            pick = CMB_EURO;
                else if (combo_holds(CMB_TURBO, ab, sc, up))           pick = CMB_TURBO;
                else if (!mega && combo_holds(CMB_PAUSE, ab, sc, up))  pick = CMB_PAUSE;
                else if (!mega && combo_holds(CMB_SMS_RESET, ab, sc, up))
                    pick = CMB_SMS_RESET;
                else if (combo_holds(CMB_CYCLE, ab, sc, up))           pick = CMB_CYCLE;
                else                                                   pick = CMB_NONE;

                if (pick == CMB_NONE) begin
                    hold_cnt = '0;
                end else if (pick == active_combo) begin
                    if (hold_cnt != CNT_TOP) hold_cnt = hold_cnt + 1'b1;
                end else begin
                    hold_cnt = {{(CNT_W-1){1'b0}}, 1'b1};
                end
                active_combo = pick;

                if (pick != CMB_NONE) begin
                    thr = (pick == CMB_SMS_RESET) ? cfg_long : cfg_hold;
                    if (hold_cnt == thr) begin
                        case (pick)
                            CMB_RESET: begin
                                if (euro_ok) apply_region(REGION_EUROPE);
                                rs = 1'b1;
                            end
                            CMB_EURO: begin
                                if (euro_ok) begin
                                    ntsc_q = ~ntsc_q;
                                    fast_q = 1'b0;
                                end
                            end
                            CMB_TURBO: begin
                                oc_q   = ~oc_q;
                                fast_q = oc_q;
                            end
                            CMB_PAUSE:     pz = 1'b1;
                            CMB_SMS_RESET: sr = 1'b1;
                            default: begin
                                next_region();
                                sv = 1'b1;
                                rs = 1'b1;
                            end
                        endcase
                    end
                end else begin
                    if (press_age != CNT_TOP) press_age = press_age + 1'b1;
                    if (mega) begin
                        if (press_age >= cfg_window) begin
                            presses = '0;
                        end else if (presses >= PRESS_CYCLE_MIN) begin
                            next_region();
                            sv = 1'b1;
                            rs = 1'b1;
                        end
                    end
                end
                if (rs) presses = '0;
            end
            KIND_SEL_FALL: begin
                pad_state[0] = !ab;
                pad_state[2] = !sc;
            end
            KIND_SEL_RISE: begin
                pad_state[1] = !ab;
                pad_state[3] = !sc;
            end
            KIND_RST_FALL: begin
                if (presses != PRESS_TOP) presses = presses + 1'b1;
                if (presses == 3'd1) press_age = '0;
            end
            KIND_MRST_FALL: begin
                if (up) begin
                    tm      = 1'b1;
                    presses = '0;
                end
            end
            default: ;
        endcase

        r               = '0;
        r.region        = region_q;
        r.standard_ntsc = ntsc_q;
        r.region_export = (region_q != REGION_JAPAN);
        r.overclock     = oc_q;
        r.cpu_divider   = fast_q ? DIV_FAST : DIV_STD;
        r.reset_pulse   = rs;
        r.sms_pause     = pz;
        r.sms_reset     = sr;
        r.save_region   = sv;
        r.tmss_skip     = tm;
        r.led_color     = region_q + 2'd1;
        return r;
    endfunction

    function automatic t_result americas_out(logic rst, logic save, logic tmss);
        t_result r;
        r               = '0;
        r.region        = REGION_AMERICAS;
        r.standard_ntsc = 1'b1;
        r.region_export = 1'b1;
        r.cpu_divider   = DIV_STD;
        r.reset_pulse   = rst;
        r.save_region   = save;
        r.tmss_skip     = tmss;
        r.led_color     = LED_GREEN;
        return r;
    endfunction

    function automatic int unsigned span_upto(int limit);
        return $urandom_range(0, (limit > SPAN_CAP) ? SPAN_CAP : limit);
    endfunction

    // ---------------- input side ----------------
    task automatic send_event(input logic [2:0] kind, input logic ab, input logic sc,
                              input logic up, input logic mega,
                              input bit typed = 1'b0, input t_result want = '0);
        int unsigned gap;
        t_result     predicted;
        gap = gaps_on ? $urandom_range(0, 14) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, mega, up, sc, ab};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        predicted = hotkey_predict(kind, ab, sc, up, mega);
        pending_outputs.push_back(typed ? want : predicted);
        beats_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic reg_write(input t_reg_idx idx, input logic [12:0] val);
        logic [31:0] rd;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {19'd0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        model_config(idx, val);
        // read back
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_STORED_REGION) val = {11'd0, val[1:0]};
        if (rd != {19'd0, val}) begin
            mismatch_cnt++;
            $error("prdata reg %0d: expected %0h, actual %0h", idx, val, rd);
        end
    endtask

    task automatic configure(input logic [1:0] stored, input logic [12:0] hold,
                             input logic [12:0] long_hold, input logic [12:0] window);
        wait_drained();
        reg_write(REG_HOLD_TICKS, hold);
        reg_write(REG_LONG_HOLD, long_hold);
        reg_write(REG_PRESS_WINDOW, window);
        reg_write(REG_STORED_REGION, {11'd0, stored});
    endtask

    task automatic load_pad(input logic [3:0] pads, input logic mega);
        send_event(KIND_SEL_FALL, !pads[0], !pads[2], 1'($urandom), mega);
        send_event(KIND_SEL_RISE, !pads[1], !pads[3], 1'($urandom), mega);
    endtask

    task automatic random_traffic(input int unsigned n_items);
        int unsigned stop_at, len, pick, i, k;
        logic [3:0]  pads;
        logic        mega, ab, m;
        stop_at = beats_sent + n_items;
        while (beats_sent < stop_at) begin
            gaps_on = ($urandom_range(0, 7) != 0);
            pick    = $urandom_range(0, 99);
            if (pick < 40) begin
                // pad combo hold
                case ($urandom_range(0, 4))
                    0:       pads = PADS_RESET;
                    1:       pads = PADS_EURO;
                    2:       pads = PADS_TURBO;
                    3:       pads = PADS_CYCLE;
                    default: pads = 4'($urandom);
                endcase
                mega = ($urandom_range(0, 9) != 0);
                load_pad(pads, mega);
                len = span_upto(int'(cfg_hold) + 3);
                for (i = 0; i < len; i++) begin
                    if ($urandom_range(0, 19) == 0)
                        send_event($urandom_range(0, 1) ? KIND_SEL_RISE : KIND_SEL_FALL,
                                   1'($urandom), 1'($urandom), 1'($urandom), mega);
                    else
                        send_event(KIND_TICK, 1'($urandom), 1'($urandom), 1'($urandom), mega);
                end
            end else if (pick < 55) begin
                // master-mode line hold, pause or reset
                if ($urandom_range(0, 9) < 7) load_pad(PADS_NONE, 1'b0);
                ab  = 1'($urandom);
                len = span_upto(int'(ab ? cfg_long : cfg_hold) + 3);
                for (i = 0; i < len; i++) begin
                    m = ($urandom_range(0, 15) == 0);
                    if ($urandom_range(0, 11) == 0)
                        send_event(KIND_TICK, 1'($urandom), 1'($urandom), 1'($urandom), m);
                    else
                        send_event(KIND_TICK, ab, 1'b0, 1'b0, m);
                end
            end else if (pick < 75) begin
                // reset-line press burst
                if ($urandom_range(0, 1)) load_pad(PADS_NONE, 1'b1);
                k = $urandom_range(1, 5);
                for (i = 0; i < k; i++) begin
                    send_event(KIND_RST_FALL, 1'($urandom), 1'($urandom), 1'($urandom), 1'b1);
                    repeat ($urandom_range(0, 2))
                        send_event(KIND_TICK, 1'b1, 1'b1, 1'b1, 1'b1);
                end
                len = span_upto(int'(cfg_window) + 2);
                for (i = 0; i < len; i++)
                    send_event(KIND_TICK, 1'b1, 1'b1, 1'($urandom), $urandom_range(0, 7) != 0);
            end else if (pick < 85) begin
                send_event(KIND_MRST_FALL, 1'($urandom), 1'($urandom), 1'($urandom),
                           1'($urandom));
            end else begin
                send_event(3'($urandom_range(0, 7)), 1'($urandom), 1'($urandom),
                           1'($urandom), 1'($urandom));
            end
        end
    endtask

    // ---------------- output side ----------------
    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatch_cnt++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    initial begin : result_side
        int unsigned stall;
        t_result     got, want;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = gaps_on ? $urandom_range(0, 14) : 0;
            if (rx_block_req) begin
                stall        = HOLD_OFF_CYCLES;
                rx_block_req = 1'b0;
            end
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            got = t_result'(m_axis_tdata[14:0]);
            if (pending_outputs.size() == 0) begin
                mismatch_cnt++;
                $error("output beat with nothing expected: %0h", m_axis_tdata);
            end else begin
                want = pending_outputs.pop_front();
                check_field("region", want.region, got.region);
                check_field("standard_ntsc", want.standard_ntsc, got.standard_ntsc);
                check_field("region_export", want.region_export, got.region_export);
                check_field("overclock", want.overclock, got.overclock);
                check_field("cpu_divider", want.cpu_divider, got.cpu_divider);
                check_field("reset_pulse", want.reset_pulse, got.reset_pulse);
                check_field("sms_pause", want.sms_pause, got.sms_pause);
                check_field("sms_reset", want.sms_reset, got.sms_reset);
                check_field("save_region", want.save_region, got.save_region);
                check_field("tmss_skip", want.tmss_skip, got.tmss_skip);
                check_field("led_color", want.led_color, got.led_color);
            end
        end
    end

    // no beat on either side and no register access for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------- main sequence ----------------
    initial begin : stimulus
        int p, i;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_TICK;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_rst_n       = 1'b0;
        mismatch_cnt  = 0;
        beats_sent    = 0;
        idle_cycles   = 0;
        gaps_on       = 1'b1;
        rx_block_req  = 1'b0;
        model_reset();

        dir_rows = '{
            '{ROW_BEAT, KIND_TICK,      1, 1, 1, 1, REG_HOLD_TICKS, 0, 1, americas_out(0, 0, 0)},
            '{ROW_BEAT, KIND_SPARE_5,   0, 0, 0, 0, REG_HOLD_TICKS, 0, 1, americas_out(0, 0, 0)},
            '{ROW_BEAT, KIND_SPARE_7,   0, 1, 0, 1, REG_HOLD_TICKS, 0, 1, americas_out(0, 0, 0)},
            '{ROW_BEAT, KIND_MRST_FALL, 1, 1, 1, 1, REG_HOLD_TICKS, 0, 1, americas_out(0, 0, 1)},
            '{ROW_BEAT, KIND_MRST_FALL, 0, 0, 0, 1, REG_HOLD_TICKS, 0, 1, americas_out(0, 0, 0)},
            '{ROW_BEAT, KIND_RST_FALL,  1, 1, 1, 1, REG_HOLD_TICKS, 0, 1, americas_out(0, 0, 0)},
            '{ROW_BEAT, KIND_RST_FALL,  1, 1, 1, 1, REG_HOLD_TICKS, 0, 1, americas_out(0, 0, 0)},
            '{ROW_BEAT, KIND_RST_FALL,  1, 1, 1, 1, REG_HOLD_TICKS, 0, 1, americas_out(0, 0, 0)},
            // third press inside the window: cycle to americas, save, reset
            '{ROW_BEAT, KIND_TICK,      1, 1, 1, 1, REG_HOLD_TICKS, 0, 1, americas_out(1, 1, 0)},
            '{ROW_BEAT, KIND_RST_FALL,  1, 1, 1, 1, REG_HOLD_TICKS, 0, 1, americas_out(0, 0, 0)},
            '{ROW_BEAT, KIND_MRST_FALL, 1, 1, 1, 1, REG_HOLD_TICKS, 0, 1, americas_out(0, 0, 1)},
            '{ROW_BEAT, KIND_TICK,      1, 1, 1, 0, REG_HOLD_TICKS, 0, 1, americas_out(0, 0, 0)},
            '{ROW_REG,  KIND_TICK,      1, 1, 1, 1, REG_HOLD_TICKS, 1, 0, '0},
            '{ROW_REG,  KIND_TICK,      1, 1, 1, 1, REG_LONG_HOLD, 1, 0, '0},
            '{ROW_REG,  KIND_TICK,      1, 1, 1, 1, REG_PRESS_WINDOW, 1, 0, '0},
            '{ROW_REG,  KIND_TICK,      1, 1, 1, 1, REG_STORED_REGION, 13'(REGION_EUROPE), 0, '0},
            '{ROW_BEAT, KIND_SEL_FALL,  0, 0, 1, 1, REG_HOLD_TICKS, 0, 0, '0},
            '{ROW_BEAT, KIND_SEL_RISE,  0, 0, 1, 1, REG_HOLD_TICKS, 0, 0, '0},
            '{ROW_BEAT, KIND_TICK,      1, 1, 1, 1, REG_HOLD_TICKS, 0, 0, '0},
            '{ROW_BEAT, KIND_SEL_RISE,  0, 1, 1, 1, REG_HOLD_TICKS, 0, 0, '0},
            '{ROW_BEAT, KIND_TICK,      1, 1, 1, 1, REG_HOLD_TICKS, 0, 0, '0},
            '{ROW_BEAT, KIND_SEL_RISE,  1, 1, 1, 1, REG_HOLD_TICKS, 0, 0, '0},
            '{ROW_BEAT, KIND_TICK,      1, 1, 1, 1, REG_HOLD_TICKS, 0, 0, '0},
            '{ROW_BEAT, KIND_SEL_FALL,  1, 1, 1, 1, REG_HOLD_TICKS, 0, 0, '0},
            '{ROW_BEAT, KIND_TICK,      0, 0, 0, 0, REG_HOLD_TICKS, 0, 0, '0},
            '{ROW_BEAT, KIND_TICK,      1, 0, 0, 0, REG_HOLD_TICKS, 0, 0, '0},
            '{ROW_BEAT, KIND_SEL_FALL,  1, 0, 1, 1, REG_HOLD_TICKS, 0, 0, '0},
            '{ROW_BEAT, KIND_SEL_RISE,  0, 0, 1, 1, REG_HOLD_TICKS, 0, 0, '0},
            '{ROW_BEAT, KIND_TICK,      1, 1, 1, 1, REG_HOLD_TICKS, 0, 0, '0}
        };

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].op == ROW_REG) begin
                wait_drained();
                reg_write(dir_rows[i].reg_sel, dir_rows[i].reg_val);
            end else begin
                send_event(dir_rows[i].kind, dir_rows[i].ab, dir_rows[i].sc, dir_rows[i].up,
                           dir_rows[i].mega, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (p = 0; p < 6; p++) begin
            case (p)
                1:       configure(REGION_JAPAN, 13'd1, 13'd1, 13'd1);
                2:       configure(2'($urandom), 13'($urandom_range(2, 15)),
                                   13'($urandom_range(8, 30)), 13'($urandom_range(5, 40)));
                3:       configure(REGION_INVALID, CNT_TOP, CNT_TOP, CNT_TOP);
                default: configure(2'($urandom), 13'($urandom_range(1, 6)),
                                   13'($urandom_range(1, 10)), 13'($urandom_range(1, 12)));
            endcase
            if (p == 2) begin
                // receiver holds off while items keep coming, then a full drain
                rx_block_req = 1'b1;
                random_traffic(105);
                wait_drained();
                random_traffic(110);
            end else begin
                random_traffic(215);
            end
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/hkc_pkg.sv
rtl/hkc_cfg.sv
rtl/hkc_core.sv
rtl/console_mod_hotkey_controller_top.sv
dv/console_mod_hotkey_controller_top_tb.sv
